// ----- sv/tsu_pkg.sv -----
// Shared types, constants and register map of the torus sphere trace unit.
package tsu_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned STEP_LIMIT_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Field and internal datapath widths.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MAG_W   = 33;
  localparam int unsigned LEN_W   = 35;
  localparam int unsigned DIST_W  = 36;
  localparam int unsigned RAD_W   = 31;
  localparam int unsigned EPS_W   = 16;
  localparam int unsigned STEPS_W = 7;

  // Iterative divider: 64-bit dividend, 35-bit divisor, 32 quotient bits.
  localparam int unsigned DIV_NUM_W = 64;
  localparam int unsigned DIV_DEN_W = 35;
  localparam int unsigned DIV_QUO_W = 32;

  // Iterative square root: 64-bit radicand, 32-bit root.
  localparam int unsigned SQRT_IN_W  = 64;
  localparam int unsigned SQRT_OUT_W = 32;

  // Iteration counters of the two shared units.
  localparam int unsigned ITER_CNT_W = 6;

  // Request queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [1:0] REG_MAJOR_RADIUS = 2'd0;
  localparam logic [1:0] REG_MINOR_RADIUS = 2'd1;
  localparam logic [1:0] REG_HIT_EPSILON  = 2'd2;
  localparam logic [1:0] REG_MAX_STEPS    = 2'd3;

  localparam logic [RAD_W-1:0]   MAJOR_RADIUS_RST = 31'd65536;
  localparam logic [RAD_W-1:0]   MINOR_RADIUS_RST = 31'd32768;
  localparam logic [EPS_W-1:0]   HIT_EPSILON_RST  = 16'd1;
  localparam logic [STEPS_W-1:0] MAX_STEPS_RST    = 7'd16;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic [RAD_W-1:0]   major_radius;
    logic [RAD_W-1:0]   minor_radius;
    logic [EPS_W-1:0]   hit_epsilon;
    logic [STEPS_W-1:0] max_steps;
  } cfg_t;

  // One queued request with its classification.
  typedef struct packed {
    logic [DATA_W-1:0] start_x;
    logic [DATA_W-1:0] start_y;
    logic [DATA_W-1:0] start_z;
    logic [DATA_W-1:0] dir_x;
    logic [DATA_W-1:0] dir_y;
    logic [DATA_W-1:0] dir_z;
    logic              dir_zero;
  } item_t;

endpackage

// ----- sv/torus_sphere_trace_unit.sv -----
// Top level of the torus sphere trace unit: configuration registers, front and back end.
//
// A request is a ray start point and direction in signed Q16.16. It is taken
// at a rising edge with start high and busy low, and waits in a two-deep queue
// until the back end is free. busy is high only while that queue is full.
// The back end scales the direction to unit length, then sphere-traces a torus
// around the x axis and returns the saturated travelled distance on
// travel_distance_o, marked by done_o high for a single cycle. The receiver cannot stall.
// It evaluates the distance at most N + 1 times, N being the effective step limit;
// the time per request is set by the shared iterative square root and divider
// (one bit per cycle each): each distance evaluation takes two roots and up to
// two divisions, normalisation one root and three divisions. An evaluation
// near the axis skips both divisions. A zero direction skips normalisation.
// Requests are processed one at a time. Reset empties the queue, stops any march
// and restores the register defaults. Registers sit on an APB-style port at byte
// addresses 0, 4, 8 and 12. The user must see that they are written only while
// the unit is idle; the block itself does not enforce this.
module torus_sphere_trace_unit #(
  parameter int unsigned STEP_LIMIT = tsu_pkg::STEP_LIMIT_DEF,
  parameter int unsigned FRAC_BITS  = tsu_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsu_pkg::PADDR_W-1:0]        paddr,
  input  logic [tsu_pkg::PDATA_W-1:0]        pwdata,
  output logic [tsu_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tsu_pkg::DATA_W-1:0]  start_x_i,
  input  logic signed [tsu_pkg::DATA_W-1:0]  start_y_i,
  input  logic signed [tsu_pkg::DATA_W-1:0]  start_z_i,
  input  logic signed [tsu_pkg::DATA_W-1:0]  dir_x_i,
  input  logic signed [tsu_pkg::DATA_W-1:0]  dir_y_i,
  input  logic signed [tsu_pkg::DATA_W-1:0]  dir_z_i,
  output logic                               done_o,
  output logic signed [tsu_pkg::DATA_W-1:0]  travel_distance_o
);

  tsu_pkg::cfg_t  cfg_q;
  tsu_pkg::item_t q_item_w;
  logic           q_valid_w;
  logic           q_pop_w;
  logic           wr_en_w;

  assign pready  = 1'b1;
  assign wr_en_w = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.major_radius <= tsu_pkg::MAJOR_RADIUS_RST;
      cfg_q.minor_radius <= tsu_pkg::MINOR_RADIUS_RST;
      cfg_q.hit_epsilon  <= tsu_pkg::HIT_EPSILON_RST;
      cfg_q.max_steps    <= tsu_pkg::MAX_STEPS_RST;
    end else if (wr_en_w) begin
      unique case (paddr[3:2])
        tsu_pkg::REG_MAJOR_RADIUS: cfg_q.major_radius <= pwdata[tsu_pkg::RAD_W-1:0];
        tsu_pkg::REG_MINOR_RADIUS: cfg_q.minor_radius <= pwdata[tsu_pkg::RAD_W-1:0];
        tsu_pkg::REG_HIT_EPSILON:  cfg_q.hit_epsilon  <= pwdata[tsu_pkg::EPS_W-1:0];
        tsu_pkg::REG_MAX_STEPS:    cfg_q.max_steps    <= pwdata[tsu_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      tsu_pkg::REG_MAJOR_RADIUS: prdata = tsu_pkg::PDATA_W'(cfg_q.major_radius);
      tsu_pkg::REG_MINOR_RADIUS: prdata = tsu_pkg::PDATA_W'(cfg_q.minor_radius);
      tsu_pkg::REG_HIT_EPSILON:  prdata = tsu_pkg::PDATA_W'(cfg_q.hit_epsilon);
      tsu_pkg::REG_MAX_STEPS:    prdata = tsu_pkg::PDATA_W'(cfg_q.max_steps);
      default:                   prdata = '0;
    endcase
  end

  tsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .start_z_i (start_z_i),
    .dir_x_i   (dir_x_i),
    .dir_y_i   (dir_y_i),
    .dir_z_i   (dir_z_i),
    .busy      (busy),
    .q_valid_o (q_valid_w),
    .q_item_o  (q_item_w),
    .q_pop_i   (q_pop_w)
  );

  tsu_back #(
    .STEP_LIMIT (STEP_LIMIT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (q_valid_w),
    .q_item_i          (q_item_w),
    .q_pop_o           (q_pop_w),
    .done_o            (done_o),
    .travel_distance_o (travel_distance_o)
  );

endmodule

// ----- sv/tsu_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module tsu_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [tsu_pkg::DIV_NUM_W-1:0]       num_i,
  input  logic [tsu_pkg::DIV_DEN_W-1:0]       den_i,
  output logic                                done_o,
  output logic [tsu_pkg::DIV_QUO_W-1:0]       quo_o
);

  localparam int unsigned NW = tsu_pkg::DIV_NUM_W;
  localparam int unsigned DW = tsu_pkg::DIV_DEN_W;
  localparam int unsigned QW = tsu_pkg::DIV_QUO_W;
  localparam int unsigned CW = tsu_pkg::ITER_CNT_W;

  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] lo_q, lo_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;
  logic [DW:0]   trial_w;
  logic          ge_w;

  // One step: bring down the next dividend bit and try a subtraction.
  always_comb begin
    trial_w = {rem_q, lo_q[QW-1]};
    ge_w    = trial_w >= {1'b0, den_q};
    rem_d   = ge_w ? DW'(trial_w - {1'b0, den_q}) : DW'(trial_w);
    lo_d    = {lo_q[QW-2:0], ge_w};
  end

  // Control: iteration count and completion strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(QW);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient collects in the low word as the dividend leaves it.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(num_i[NW-1:QW]);
      lo_q  <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = lo_q;

endmodule

// ----- sv/tsu_isqrt.sv -----
// Bitwise integer square root, one root bit per cycle.
module tsu_isqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [tsu_pkg::SQRT_IN_W-1:0]      rad_i,
  output logic                               done_o,
  output logic [tsu_pkg::SQRT_OUT_W-1:0]     root_o
);

  localparam int unsigned IW = tsu_pkg::SQRT_IN_W;
  localparam int unsigned OW = tsu_pkg::SQRT_OUT_W;
  localparam int unsigned RW = OW + 2;
  localparam int unsigned CW = tsu_pkg::ITER_CNT_W;

  logic [RW-1:0] rem_q, rem_d;
  logic [OW-1:0] root_q, root_d;
  logic [IW-1:0] x_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;
  logic [RW+1:0] t_w;
  logic [RW+1:0] trial_w;
  logic          ge_w;

  // One step: take two radicand bits and test the next root bit.
  always_comb begin
    t_w     = {rem_q, x_q[IW-1:IW-2]};
    trial_w = (RW+2)'({root_q, 2'b01});
    ge_w    = t_w >= trial_w;
    rem_d   = ge_w ? RW'(t_w - trial_w) : RW'(t_w);
    root_d  = {root_q[OW-2:0], ge_w};
  end

  // Control: iteration count and completion strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(OW);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      root_q <= '0;
      x_q    <= rad_i;
    end else if (run_q) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      x_q    <= {x_q[IW-3:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- sv/tsu_front.sv -----
// Front end: takes requests, flags a zero direction and queues them for the back end.
module tsu_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic signed [tsu_pkg::DATA_W-1:0] start_x_i,
  input  logic signed [tsu_pkg::DATA_W-1:0] start_y_i,
  input  logic signed [tsu_pkg::DATA_W-1:0] start_z_i,
  input  logic signed [tsu_pkg::DATA_W-1:0] dir_x_i,
  input  logic signed [tsu_pkg::DATA_W-1:0] dir_y_i,
  input  logic signed [tsu_pkg::DATA_W-1:0] dir_z_i,
  output logic                            busy,
  output logic                            q_valid_o,
  output tsu_pkg::item_t                  q_item_o,
  input  logic                            q_pop_i
);

  tsu_pkg::item_t                    mem_q [tsu_pkg::QUEUE_DEPTH];
  tsu_pkg::item_t                    item_w;
  logic [tsu_pkg::QPTR_W-1:0]        wr_ptr_q;
  logic [tsu_pkg::QPTR_W-1:0]        rd_ptr_q;
  logic [tsu_pkg::QCNT_W-1:0]        cnt_q;
  logic                              push_w;
  logic                              pop_w;

  // Classify the incoming request.
  always_comb begin
    item_w.start_x  = start_x_i;
    item_w.start_y  = start_y_i;
    item_w.start_z  = start_z_i;
    item_w.dir_x    = dir_x_i;
    item_w.dir_y    = dir_y_i;
    item_w.dir_z    = dir_z_i;
    item_w.dir_zero = (dir_x_i == '0) && (dir_y_i == '0) && (dir_z_i == '0);
  end

  assign busy   = cnt_q == tsu_pkg::QCNT_W'(tsu_pkg::QUEUE_DEPTH);
  assign push_w = start && !busy;
  assign pop_w  = q_pop_i && (cnt_q != '0);

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_w) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_w)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_w && !pop_w)      cnt_q <= cnt_q + 1'b1;
      else if (pop_w && !push_w) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_w) mem_q[wr_ptr_q] <= item_w;
  end

  assign q_valid_o = cnt_q != '0;
  assign q_item_o  = mem_q[rd_ptr_q];

endmodule

// ----- sv/tsu_back.sv -----
// Back end: sequencer that normalises the direction and marches the ray.
module tsu_back #(
  parameter int unsigned STEP_LIMIT = tsu_pkg::STEP_LIMIT_DEF,
  parameter int unsigned FRAC_BITS  = tsu_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tsu_pkg::cfg_t                     cfg_i,
  input  logic                              q_valid_i,
  input  tsu_pkg::item_t                    q_item_i,
  output logic                              q_pop_o,
  output logic                              done_o,
  output logic signed [tsu_pkg::DATA_W-1:0] travel_distance_o
);

  localparam int unsigned DW    = tsu_pkg::DATA_W;
  localparam int unsigned MW    = tsu_pkg::MAG_W;
  localparam int unsigned LW    = tsu_pkg::LEN_W;
  localparam int unsigned SW    = tsu_pkg::DIST_W;
  localparam int unsigned UW    = FRAC_BITS + 2;
  localparam int unsigned CNT_W = $clog2(STEP_LIMIT + 1);
  localparam int unsigned IT_W  = (CNT_W > tsu_pkg::STEPS_W) ? CNT_W : tsu_pkg::STEPS_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SQ        = 4'd1;
  localparam logic [3:0] ST_SQ_ADD    = 4'd2;
  localparam logic [3:0] ST_ROOT_GO   = 4'd3;
  localparam logic [3:0] ST_ROOT_WAIT = 4'd4;
  localparam logic [3:0] ST_UDIV_GO   = 4'd5;
  localparam logic [3:0] ST_UDIV_WAIT = 4'd6;
  localparam logic [3:0] ST_ADV_MUL   = 4'd7;
  localparam logic [3:0] ST_ADV_ADD   = 4'd8;
  localparam logic [3:0] ST_RHO_SET   = 4'd9;
  localparam logic [3:0] ST_PMUL      = 4'd10;
  localparam logic [3:0] ST_PDIV_GO   = 4'd11;
  localparam logic [3:0] ST_PDIV_WAIT = 4'd12;
  localparam logic [3:0] ST_TDIST_SET = 4'd13;

  // Which length is being taken.
  localparam logic [1:0] LEN_NORM  = 2'd0;
  localparam logic [1:0] LEN_RHO   = 2'd1;
  localparam logic [1:0] LEN_TDIST = 2'd2;

  function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
    mag32 = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [MW-1:0] mag33(input logic signed [MW-1:0] v);
    mag33 = v[MW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [SW-1:0] mag36(input logic signed [SW-1:0] v);
    mag36 = v[SW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi)      sat32 = 32'sh7FFF_FFFF;
    else if (v < lo) sat32 = 32'sh8000_0000;
    else             sat32 = DW'(v);
  endfunction

  logic [3:0]             state_q, state_d;
  logic [1:0]             idx_q, idx_d;
  logic [1:0]             len_sel_q, len_sel_d;
  logic signed [DW-1:0]   pos_q [3];
  logic signed [DW-1:0]   pos_d [3];
  logic signed [DW-1:0]   dir_q [3];
  logic signed [DW-1:0]   dir_d [3];
  logic signed [UW-1:0]   u_q [3];
  logic signed [UW-1:0]   u_d [3];
  logic [MW-1:0]          m_q [3];
  logic [MW-1:0]          m_d [3];
  logic signed [DW-1:0]   acc_q, acc_d;
  logic signed [SW-1:0]   dist_q, dist_d;
  logic [IT_W-1:0]        it_q, it_d;
  logic [63:0]            sum_q, sum_d;
  logic [63:0]            prod_q, prod_d;
  logic [LW-1:0]          len_q, len_d;
  logic signed [DW-1:0]   py_q, py_d;
  logic signed [DW-1:0]   pz_q, pz_d;
  logic signed [DW-1:0]   travel_q, travel_d;
  logic                   done_q, done_d;

  logic [MW-1:0]          or_w;
  logic [1:0]             shift_w;
  logic [30:0]            sq_op_w;
  logic [35:0]            mul_a_w;
  logic [31:0]            mul_b_w;
  logic [67:0]            mul_p_w;
  logic [UW-1:0]          magu_w;
  logic [IT_W-1:0]        limit_w;
  logic [LW-1:0]          len_w;
  logic signed [SW-1:0]   dist_w;
  logic [63:0]            rnd_w;
  logic                   step_neg_w;
  logic signed [63:0]     pos_sum_w;
  logic signed [63:0]     acc_sum_w;
  logic signed [MW-1:0]   dy_w;
  logic signed [MW-1:0]   dz_w;
  logic [UW-1:0]          uq_w;
  logic signed [DW-1:0]   pq_w;

  logic                   div_start_w;
  logic [63:0]            div_num_w;
  logic                   div_done_w;
  logic [31:0]            div_quo_w;
  logic                   sqrt_start_w;
  logic                   sqrt_done_w;
  logic [31:0]            sqrt_root_w;

  // Shared units.
  tsu_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_w),
    .num_i   (div_num_w),
    .den_i   (len_q),
    .done_o  (div_done_w),
    .quo_o   (div_quo_w)
  );

  tsu_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_w),
    .rad_i   (sum_q),
    .done_o  (sqrt_done_w),
    .root_o  (sqrt_root_w)
  );

  // Common pre-shift so that every squared operand stays below 2^31.
  assign or_w    = m_q[0] | m_q[1] | m_q[2];
  assign shift_w = or_w[MW-1] ? 2'd2 : (or_w[MW-2] ? 2'd1 : 2'd0);
  assign sq_op_w = 31'(m_q[idx_q] >> shift_w);
  assign magu_w  = u_q[idx_q][UW-1] ? (~u_q[idx_q] + 1'b1) : u_q[idx_q];

  // Effective iteration limit.
  always_comb begin
    if (IT_W'(cfg_i.max_steps) > IT_W'(STEP_LIMIT)) limit_w = IT_W'(STEP_LIMIT);
    else                                            limit_w = IT_W'(cfg_i.max_steps);
  end

  // The single multiplier: squares, ring projection and step scaling.
  always_comb begin
    unique case (state_q)
      ST_SQ: begin
        mul_a_w = 36'(sq_op_w);
        mul_b_w = 32'(sq_op_w);
      end
      ST_ADV_MUL: begin
        mul_a_w = mag36(dist_q);
        mul_b_w = 32'(magu_w);
      end
      ST_PMUL: begin
        mul_a_w = 36'(cfg_i.major_radius);
        mul_b_w = mag32(pos_q[idx_q]);
      end
      default: begin
        mul_a_w = '0;
        mul_b_w = '0;
      end
    endcase
  end
  assign mul_p_w = 68'(mul_a_w) * 68'(mul_b_w);

  // Arithmetic around the sequencer.
  assign len_w      = LW'(sqrt_root_w) << shift_w;
  assign dist_w     = $signed({1'b0, len_w}) - $signed(SW'(cfg_i.minor_radius));
  assign rnd_w      = (prod_q + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign step_neg_w = dist_q[SW-1] ^ u_q[idx_q][UW-1];
  assign pos_sum_w  = 64'(pos_q[idx_q])
                      + (step_neg_w ? -$signed(rnd_w) : $signed(rnd_w));
  assign acc_sum_w  = 64'(acc_q) + 64'(dist_q);
  assign dy_w       = MW'(pos_q[1]) - MW'(py_q);
  assign dz_w       = MW'(pos_q[2]) - MW'(pz_q);
  assign uq_w       = UW'(div_quo_w[FRAC_BITS:0]);
  assign pq_w       = DW'({1'b0, div_quo_w[30:0]});

  // Divider operand: unit scaling or ring projection.
  assign div_num_w   = (state_q == ST_UDIV_GO) ? (64'(mag32(dir_q[idx_q])) << FRAC_BITS)
                                               : prod_q;
  assign div_start_w = (state_q == ST_UDIV_GO) || (state_q == ST_PDIV_GO);
  assign sqrt_start_w = state_q == ST_ROOT_GO;
  assign q_pop_o      = (state_q == ST_IDLE) && q_valid_i;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    len_sel_d = len_sel_q;
    pos_d     = pos_q;
    dir_d     = dir_q;
    u_d       = u_q;
    m_d       = m_q;
    acc_d     = acc_q;
    dist_d    = dist_q;
    it_d      = it_q;
    sum_d     = sum_q;
    prod_d    = prod_q;
    len_d     = len_q;
    py_d      = py_q;
    pz_d      = pz_q;
    travel_d  = travel_q;
    done_d    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pos_d[0] = q_item_i.start_x;
          pos_d[1] = q_item_i.start_y;
          pos_d[2] = q_item_i.start_z;
          dir_d[0] = q_item_i.dir_x;
          dir_d[1] = q_item_i.dir_y;
          dir_d[2] = q_item_i.dir_z;
          acc_d    = '0;
          dist_d   = '0;
          it_d     = '0;
          idx_d    = '0;
          if (q_item_i.dir_zero) begin
            // No direction: the point stays put, the march still counts.
            u_d[0]  = '0;
            u_d[1]  = '0;
            u_d[2]  = '0;
            state_d = ST_ADV_MUL;
          end else begin
            m_d[0]    = MW'(mag32(q_item_i.dir_x));
            m_d[1]    = MW'(mag32(q_item_i.dir_y));
            m_d[2]    = MW'(mag32(q_item_i.dir_z));
            sum_d     = '0;
            len_sel_d = LEN_NORM;
            state_d   = ST_SQ;
          end
        end
      end

      // Sum of squares, one product per cycle.
      ST_SQ: begin
        prod_d = mul_p_w[63:0];
        if (idx_q != 2'd0) sum_d = sum_q + prod_q;
        if (idx_q == 2'd2) begin
          state_d = ST_SQ_ADD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_SQ_ADD: begin
        sum_d   = sum_q + prod_q;
        state_d = ST_ROOT_GO;
      end

      ST_ROOT_GO: begin
        state_d = ST_ROOT_WAIT;
      end

      ST_ROOT_WAIT: begin
        if (sqrt_done_w) begin
          len_d = len_w;
          unique case (len_sel_q)
            LEN_NORM: begin
              idx_d = '0;
              if (len_w == '0) begin
                u_d[0]  = '0;
                u_d[1]  = '0;
                u_d[2]  = '0;
                state_d = ST_ADV_MUL;
              end else begin
                state_d = ST_UDIV_GO;
              end
            end
            LEN_RHO: begin
              if (len_w > LW'(cfg_i.hit_epsilon)) begin
                idx_d   = 2'd1;
                state_d = ST_PMUL;
              end else begin
                // Near the axis the nearest ring point is taken on the z axis.
                py_d    = '0;
                pz_d    = DW'(cfg_i.major_radius);
                state_d = ST_TDIST_SET;
              end
            end
            default: begin
              dist_d = dist_w;
              if ((it_q < limit_w) && (dist_w > $signed(SW'(cfg_i.hit_epsilon)))) begin
                it_d    = it_q + 1'b1;
                idx_d   = '0;
                state_d = ST_ADV_MUL;
              end else begin
                // The last distance found is not added to the total.
                travel_d = acc_q;
                done_d   = 1'b1;
                state_d  = ST_IDLE;
              end
            end
          endcase
        end
      end

      // Unit direction, one component per division.
      ST_UDIV_GO: begin
        state_d = ST_UDIV_WAIT;
      end

      ST_UDIV_WAIT: begin
        if (div_done_w) begin
          u_d[idx_q] = dir_q[idx_q][DW-1] ? -$signed(uq_w) : $signed(uq_w);
          if (idx_q == 2'd2) begin
            idx_d   = '0;
            state_d = ST_ADV_MUL;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_UDIV_GO;
          end
        end
      end

      // Advance the point along the ray, one coordinate at a time.
      ST_ADV_MUL: begin
        prod_d  = mul_p_w[63:0];
        state_d = ST_ADV_ADD;
      end

      ST_ADV_ADD: begin
        pos_d[idx_q] = sat32(pos_sum_w);
        if (idx_q == 2'd2) begin
          acc_d   = sat32(acc_sum_w);
          state_d = ST_RHO_SET;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_ADV_MUL;
        end
      end

      ST_RHO_SET: begin
        m_d[0]    = '0;
        m_d[1]    = MW'(mag32(pos_q[1]));
        m_d[2]    = MW'(mag32(pos_q[2]));
        sum_d     = '0;
        idx_d     = '0;
        len_sel_d = LEN_RHO;
        state_d   = ST_SQ;
      end

      // Projection of y and z onto the ring.
      ST_PMUL: begin
        prod_d  = mul_p_w[63:0];
        state_d = ST_PDIV_GO;
      end

      ST_PDIV_GO: begin
        state_d = ST_PDIV_WAIT;
      end

      ST_PDIV_WAIT: begin
        if (div_done_w) begin
          if (idx_q == 2'd1) begin
            py_d    = pos_q[1][DW-1] ? -pq_w : pq_w;
            idx_d   = 2'd2;
            state_d = ST_PMUL;
          end else begin
            pz_d    = pos_q[2][DW-1] ? -pq_w : pq_w;
            state_d = ST_TDIST_SET;
          end
        end
      end

      ST_TDIST_SET: begin
        m_d[0]    = MW'(mag32(pos_q[0]));
        m_d[1]    = mag33(dy_w);
        m_d[2]    = mag33(dz_w);
        sum_d     = '0;
        idx_d     = '0;
        len_sel_d = LEN_TDIST;
        state_d   = ST_SQ;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    len_sel_q <= len_sel_d;
    pos_q     <= pos_d;
    dir_q     <= dir_d;
    u_q       <= u_d;
    m_q       <= m_d;
    acc_q     <= acc_d;
    dist_q    <= dist_d;
    it_q      <= it_d;
    sum_q     <= sum_d;
    prod_q    <= prod_d;
    len_q     <= len_d;
    py_q      <= py_d;
    pz_q      <= pz_d;
    travel_q  <= travel_d;
  end

  assign done_o            = done_q;
  assign travel_distance_o = travel_q;

endmodule
